// File: hw/rtl/zimd_pkg.sv
// Shared types, constants and the microcode table of the zigzag distance unit.
package zimd_pkg;

  localparam int unsigned INDEX_WIDTH_DEF = 31;
  localparam int unsigned DIST_WIDTH = 17;
  localparam int unsigned OUT_TDATA_WIDTH = ((DIST_WIDTH + 7) / 8) * 8;

  // Step counter width and the step addresses of the microprogram.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_A0 = 4'd1;
  localparam logic [STEP_W-1:0] STEP_LOOP_A = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LOOP_B = 4'd3;
  localparam logic [STEP_W-1:0] STEP_INC    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_TRI_A  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RES_A  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RES_B  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_COORD  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DIFF   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_OUT    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_LAST   = STEP_OUT;

  typedef enum logic {
    LANE_A,
    LANE_B
  } lane_e;

  typedef enum logic {
    MUL_PLAIN,
    MUL_BIT
  } mul_mode_e;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_WAIT_IN,
    COND_LOOP,
    COND_WAIT_OUT
  } cond_e;

  typedef struct packed {
    logic              in_ready;
    logic              mul_en;
    lane_e             mul_lane;
    mul_mode_e         mul_mode;
    logic              cmp_en;
    lane_e             cmp_lane;
    logic              bit_dec;
    logic              d_inc;
    logic              r_en;
    lane_e             r_lane;
    logic              coord_en;
    logic              diff_en;
    logic              out_en;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic bit_done;
    logic out_free;
  } status_t;

  // Microcode ROM: one control word per step.
  function automatic ctrl_t ctrl_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    w.cond = COND_NEXT;
    w.target = STEP_IDLE;
    case (step)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.cond = COND_WAIT_IN;
      end
      STEP_MUL_A0: begin
        w.mul_en = 1'b1;
        w.mul_lane = LANE_A;
        w.mul_mode = MUL_BIT;
      end
      STEP_LOOP_A: begin
        w.cmp_en = 1'b1;
        w.cmp_lane = LANE_A;
        w.mul_en = 1'b1;
        w.mul_lane = LANE_B;
        w.mul_mode = MUL_BIT;
        w.bit_dec = 1'b1;
      end
      STEP_LOOP_B: begin
        w.cmp_en = 1'b1;
        w.cmp_lane = LANE_B;
        w.mul_en = 1'b1;
        w.mul_lane = LANE_A;
        w.mul_mode = MUL_BIT;
        w.cond = COND_LOOP;
        w.target = STEP_LOOP_A;
      end
      STEP_INC: begin
        w.d_inc = 1'b1;
      end
      STEP_TRI_A: begin
        w.mul_en = 1'b1;
        w.mul_lane = LANE_A;
        w.mul_mode = MUL_PLAIN;
      end
      STEP_RES_A: begin
        w.r_en = 1'b1;
        w.r_lane = LANE_A;
        w.mul_en = 1'b1;
        w.mul_lane = LANE_B;
        w.mul_mode = MUL_PLAIN;
      end
      STEP_RES_B: begin
        w.r_en = 1'b1;
        w.r_lane = LANE_B;
      end
      STEP_COORD: begin
        w.coord_en = 1'b1;
      end
      STEP_DIFF: begin
        w.diff_en = 1'b1;
      end
      STEP_OUT: begin
        w.out_en = 1'b1;
        w.cond = COND_WAIT_OUT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond = COND_WAIT_OUT;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/zigzag_index_manhattan_distance_unit.sv
// Top level of the zigzag index Manhattan distance unit.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  index_a, index_b
//   m_axis    out        m_axis_tvalid / m_axis_tready  distance
//
// A request passes the search, increment, triangle, remainder, coordinate
// and difference steps on its way to the result register, and a new one is
// taken only once the program is back in its idle step. The search sets this
// pace, bit by bit, as both lanes share one multiplier and wait for its product.
// Reset clears only the step counter and the result valid flag.
// A result not taken holds the last step, so input waits until it leaves.
module zigzag_index_manhattan_distance_unit #(
  parameter int unsigned INDEX_WIDTH = zimd_pkg::INDEX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from the lowest bit up: index_a, index_b, zero padding.
  input  logic [((2 * INDEX_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from the lowest bit up: distance, zero padding.
  output logic [zimd_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

  zimd_pkg::ctrl_t   ctrl;
  zimd_pkg::status_t stat;
  logic [zimd_pkg::DIST_WIDTH-1:0] distance;

  // The sequencer steps through the microprogram and emits one control word
  // per cycle; the datapath carries out what that word asks for.
  zimd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // The request is ready only in the idle step of the program.
  assign s_axis_tready = ctrl.in_ready;

  zimd_dp #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (s_axis_tvalid),
    .index_a_i   (s_axis_tdata[INDEX_WIDTH-1:0]),
    .index_b_i   (s_axis_tdata[2*INDEX_WIDTH-1:INDEX_WIDTH]),
    .out_ready_i (m_axis_tready),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .distance_o  (distance)
  );

  // The distance sits in the low bits, the rest of the byte lane is zero.
  assign m_axis_tdata = {{(zimd_pkg::OUT_TDATA_WIDTH - zimd_pkg::DIST_WIDTH){1'b0}}, distance};

endmodule

// File: hw/rtl/zimd_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
module zimd_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  zimd_pkg::status_t stat_i,
  output zimd_pkg::ctrl_t   ctrl_o
);

  logic [zimd_pkg::STEP_W-1:0] step_q, step_d;

  assign ctrl_o = zimd_pkg::ctrl_word(step_q);

  always_comb begin
    case (ctrl_o.cond)
      zimd_pkg::COND_NEXT:     step_d = step_q + 1'b1;
      zimd_pkg::COND_WAIT_IN:  step_d = in_valid_i ? step_q + 1'b1 : step_q;
      zimd_pkg::COND_LOOP:     step_d = stat_i.bit_done ? step_q + 1'b1 : ctrl_o.target;
      zimd_pkg::COND_WAIT_OUT: step_d = stat_i.out_free ? ctrl_o.target : step_q;
      default:                 step_d = zimd_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= zimd_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= zimd_pkg::STEP_LAST)
    else $error("step counter left the microprogram");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.in_ready && in_valid_i) |=> step_q == zimd_pkg::STEP_MUL_A0)
    else $error("accepted request did not start the search");

  a_loop_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == zimd_pkg::STEP_LOOP_B && !stat_i.bit_done)
      |=> step_q == zimd_pkg::STEP_LOOP_A)
    else $error("search loop exited early");
`endif

endmodule

// File: hw/rtl/zimd_dp.sv
// Datapath: two index lanes, shared triangular-number multiplier, result register.
module zimd_dp #(
  parameter int unsigned INDEX_WIDTH = zimd_pkg::INDEX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  zimd_pkg::ctrl_t                 ctrl_i,
  input  logic                            in_valid_i,
  input  logic [INDEX_WIDTH-1:0]          index_a_i,
  input  logic [INDEX_WIDTH-1:0]          index_b_i,
  input  logic                            out_ready_i,
  output zimd_pkg::status_t               stat_o,
  output logic                            out_valid_o,
  output logic [zimd_pkg::DIST_WIDTH-1:0] distance_o
);

  localparam int unsigned SB = (INDEX_WIDTH + 1) / 2 + 1;
  localparam int unsigned PW = 2 * SB;
  localparam int unsigned CW = $clog2(SB) + 1;
  localparam int unsigned SUMW = (SB + 1 > zimd_pkg::DIST_WIDTH) ? SB + 1 : zimd_pkg::DIST_WIDTH;

  logic [INDEX_WIDTH-1:0] na_q, nb_q;
  logic [SB-1:0] da_q, db_q;
  logic [CW-1:0] bit_q;
  logic [SB-1:0] cand_q;
  logic [PW-1:0] prod_q;
  logic [SB-1:0] ra_q, rb_q;
  logic [SB-1:0] xa_q, ya_q, xb_q, yb_q;
  logic [SB-1:0] dx_q, dy_q;
  logic out_valid_q;
  logic [zimd_pkg::DIST_WIDTH-1:0] out_data_q;

  logic load;
  logic [SB-1:0] one_hot, d_mul, base, fa;
  logic [SB:0] base_p1, fb;
  logic [2*SB:0] prod_full;
  logic [INDEX_WIDTH-1:0] n_cmp, n_res;
  logic cmp_less;
  logic [PW-1:0] r_full;
  logic [SUMW-1:0] sum;
  logic out_write;

  assign load = ctrl_i.in_ready && in_valid_i;

  // Candidate diagonal and its triangular number, split so the even factor is halved.
  assign one_hot = {{(SB-1){1'b0}}, 1'b1} << bit_q[CW-2:0];
  assign d_mul = (ctrl_i.mul_lane == zimd_pkg::LANE_A) ? da_q : db_q;
  assign base = (ctrl_i.mul_mode == zimd_pkg::MUL_BIT) ? (d_mul | one_hot) : d_mul;
  assign base_p1 = {1'b0, base} + 1'b1;
  assign fa = base[0] ? base : (base >> 1);
  assign fb = base[0] ? {1'b0, base_p1[SB:1]} : base_p1;
  assign prod_full = {{(SB+1){1'b0}}, fa} * {{SB{1'b0}}, fb};

  assign n_cmp = (ctrl_i.cmp_lane == zimd_pkg::LANE_A) ? na_q : nb_q;
  assign cmp_less = prod_q < {{(PW-INDEX_WIDTH){1'b0}}, n_cmp};
  assign n_res = (ctrl_i.r_lane == zimd_pkg::LANE_A) ? na_q : nb_q;
  assign r_full = prod_q - {{(PW-INDEX_WIDTH){1'b0}}, n_res};

  assign sum = {{(SUMW-SB){1'b0}}, dx_q} + {{(SUMW-SB){1'b0}}, dy_q};

  assign stat_o.bit_done = bit_q[CW-1];
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_write = ctrl_i.out_en && stat_o.out_free;

  always_ff @(posedge clk_i) begin
    if (load) begin
      na_q <= index_a_i;
      nb_q <= index_b_i;
      da_q <= '0;
      db_q <= '0;
      bit_q <= CW'(SB - 1);
    end else begin
      if (ctrl_i.bit_dec) begin
        bit_q <= bit_q - 1'b1;
      end
      if (ctrl_i.d_inc) begin
        da_q <= da_q + 1'b1;
        db_q <= db_q + 1'b1;
      end else if (ctrl_i.cmp_en && cmp_less) begin
        if (ctrl_i.cmp_lane == zimd_pkg::LANE_A) begin
          da_q <= cand_q;
        end else begin
          db_q <= cand_q;
        end
      end
    end
    if (ctrl_i.mul_en) begin
      cand_q <= base;
      prod_q <= prod_full[PW-1:0];
    end
    if (ctrl_i.r_en) begin
      if (ctrl_i.r_lane == zimd_pkg::LANE_A) begin
        ra_q <= r_full[SB-1:0];
      end else begin
        rb_q <= r_full[SB-1:0];
      end
    end
    // Even diagonals run one way, odd diagonals the other.
    if (ctrl_i.coord_en) begin
      if (!da_q[0]) begin
        xa_q <= da_q - ra_q;
        ya_q <= ra_q + 1'b1;
      end else begin
        xa_q <= ra_q + 1'b1;
        ya_q <= da_q - ra_q;
      end
      if (!db_q[0]) begin
        xb_q <= db_q - rb_q;
        yb_q <= rb_q + 1'b1;
      end else begin
        xb_q <= rb_q + 1'b1;
        yb_q <= db_q - rb_q;
      end
    end
    if (ctrl_i.diff_en) begin
      dx_q <= (xa_q > xb_q) ? xa_q - xb_q : xb_q - xa_q;
      dy_q <= (ya_q > yb_q) ? ya_q - yb_q : yb_q - ya_q;
    end
    if (out_write) begin
      out_data_q <= sum[zimd_pkg::DIST_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_write) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o = out_data_q;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the zigzag index Manhattan distance unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDX_W = zimd_pkg::INDEX_WIDTH_DEF;
  localparam int unsigned DIST_W = zimd_pkg::DIST_WIDTH;
  localparam int unsigned IN_W = ((2 * IDX_W + 7) / 8) * 8;
  localparam int unsigned SEARCH_W = (IDX_W + 1) / 2 + 1;
  // Delay from acceptance of a request to its result register.
  localparam int unsigned LATENCY = 2 * SEARCH_W + 8;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  typedef struct {
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [DIST_W-1:0] distance;
  } pending_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // Fields from the lowest bit up: index_a, index_b, zero padding.
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // Fields from the lowest bit up: distance, zero padding.
  logic [zimd_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata;

  pending_t    distance_q[$];
  bit          idle_on = 1'b1;
  int unsigned failures = 0;

  zigzag_index_manhattan_distance_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // d(d+1)/2, halving the even factor first so nothing is lost.
  function automatic logic [63:0] triangle_number(input logic [63:0] d);
    return (d[0] == 1'b0) ? (d >> 1) * (d + 64'd1) : d * ((d + 64'd1) >> 1);
  endfunction

  // Decodes a cell number into its grid cell: the diagonal is the smallest
  // one whose triangle number reaches the index, found bit by bit.
  function automatic void cell_of_index(input logic [IDX_W-1:0] idx,
                                        output logic [63:0] col,
                                        output logic [63:0] row);
    logic [63:0] diag;
    logic [63:0] trial;
    logic [63:0] offs;
    int          b;
    diag = '0;
    for (b = SEARCH_W - 1; b >= 0; b--) begin
      trial = diag | (64'd1 << b);
      if (triangle_number(trial) < 64'(idx)) diag = trial;
    end
    diag = diag + 64'd1;
    offs = triangle_number(diag) - 64'(idx);
    if (diag[0] == 1'b0) begin
      col = diag - offs;
      row = offs + 64'd1;
    end else begin
      col = offs + 64'd1;
      row = diag - offs;
    end
  endfunction

  function automatic logic [DIST_W-1:0] zigzag_distance(input logic [IDX_W-1:0] a,
                                                        input logic [IDX_W-1:0] b);
    logic [63:0] xa, ya, xb, yb, sum;
    cell_of_index(a, xa, ya);
    cell_of_index(b, xb, yb);
    sum = ((xa > xb) ? xa - xb : xb - xa) + ((ya > yb) ? ya - yb : yb - ya);
    return sum[DIST_W-1:0];
  endfunction

  // Mix of full-range values, small numbers, neighbors of diagonal starts
  // and the top of the range, so both diagonal parities and all search
  // depths are reached.
  function automatic logic [IDX_W-1:0] pick_index();
    logic [63:0] t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return IDX_W'($urandom);
      4, 5: return IDX_W'($urandom_range(1, 300));
      6, 7: begin
        t = triangle_number(64'($urandom_range(1, 65536)))
            + 64'($urandom_range(0, 2)) - 64'd1;
        return (t > 64'(IDX_MAX)) ? IDX_MAX : IDX_W'(t);
      end
      8: return IDX_MAX - IDX_W'($urandom_range(0, 70000));
      default: return IDX_W'($urandom >> $urandom_range(1, 30));
    endcase
  endfunction

  // Sends one request; the valid stays high into the next call unless that
  // call opens an idle burst, so it is never dropped and raised in one step.
  task automatic send_request(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
    pending_t item;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({b, a});
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    item.index_a = a;
    item.index_b = b;
    item.distance = zigzag_distance(a, b);
    distance_q.push_back(item);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (distance_q.size() != 0) @(posedge clk_i);
  endtask

  // Corner indices, both diagonal parities, zero inputs and the last
  // diagonal that fits in the index field.
  task automatic test_directed();
    send_request(31'd1, 31'd1);
    send_request(31'd1, 31'd2);
    send_request(31'd2, 31'd3);
    send_request(31'd3, 31'd4);
    send_request(31'd2, 31'd6);
    send_request(31'd10, 31'd11);
    send_request(31'd15, 31'd16);
    send_request(31'd21, 31'd22);
    send_request(31'd45, 31'd55);
    send_request(IDX_MAX, IDX_MAX);
    send_request(31'd1, IDX_MAX);
    send_request(IDX_MAX, 31'd1);
    send_request(31'd0, 31'd1);
    send_request(31'd0, 31'd0);
    send_request(IDX_MAX, 31'd0);
    send_request(31'd2147450880, 31'd2147450881);
    send_request(31'd2147450880, 31'd1);
    send_request(31'h2AAA_AAAA, 31'h5555_5555);
    send_request(31'h5555_5555, 31'h2AAA_AAAA);
    send_request(31'h4000_0000, 31'h3FFF_FFFF);
  endtask

  task automatic test_random_pairs(input int unsigned count);
    logic [IDX_W-1:0] a, b;
    repeat (count) begin
      a = pick_index();
      case ($urandom_range(0, 7))
        0: b = a;
        1, 2: b = a + IDX_W'($urandom_range(0, 64)) - IDX_W'(32);
        default: b = pick_index();
      endcase
      send_request(a, b);
    end
  endtask

  // The sender holds off until the unit has returned every result.
  task automatic test_drain_pause();
    repeat (3) begin
      test_random_pairs(40);
      wait_for_results();
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    idle_on = 1'b0;
    test_random_pairs(count);
  endtask

  // Result side: checks each accepted result against the oldest request in
  // flight, then picks the ready level for the next cycle.
  initial begin : result_checker
    int unsigned stall_left;
    pending_t    want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        if (distance_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: distance %0d with no request in flight",
                     m_axis_tdata[DIST_W-1:0]);
        end else begin
          want = distance_q.pop_front();
          if (m_axis_tdata[DIST_W-1:0] !== want.distance) begin
            failures++;
            if (failures <= 10)
              $display("distance mismatch for %0d, %0d: expected %0d, got %0d",
                       want.index_a, want.index_b, want.distance,
                       m_axis_tdata[DIST_W-1:0]);
          end
        end
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_pairs(800);
    test_drain_pause();
    test_back_to_back(200);
    wait_for_results();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (failures == 0 && distance_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #4ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/zimd_pkg.sv
hw/rtl/zimd_seq.sv
hw/rtl/zimd_dp.sv
hw/rtl/zigzag_index_manhattan_distance_unit.sv
tb/tb_top.sv
